// ===== rtl/kmsd_pkg.sv =====
// Package for the key matrix scan debouncer.
// Holds default sizes, field widths and the request and result structs.
// No dependencies.
package kmsd_pkg;

    localparam int ROWS_DEFAULT = 14;
    localparam int COLS_DEFAULT = 7;

    localparam int ROW_W = 4;
    localparam int LEVEL_W = 7;
    localparam int COUNT_W = 8;
    localparam int ROW_EXT_W = 5;
    localparam int IN_TDATA_W = 16;
    localparam int OUT_TDATA_W = 16;

    localparam logic [COUNT_W-1:0] DEBOUNCE_RESET = 8'd5;

    typedef struct packed {
        logic               fire;
        logic [ROW_W-1:0]   row_index;
        logic [LEVEL_W-1:0] column_levels;
        logic               end_of_scan;
    } kmsd_req_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] stable_row;
        logic               settled;
        logic               committed;
    } kmsd_res_t;

endpackage

// ===== rtl/key_matrix_scan_debouncer.sv =====
// Top level of the key matrix scan debouncer: input register, core, result register.
// Depends on kmsd_pkg and kmsd_core.
//
//  Channel  Direction  Payload
//  s_axis   in         tdata: row_index, column_levels; tlast: end_of_scan
//  m_axis   out        tdata: stable_row, settled, committed
//  cfg      in         debounce_scans write, no read-back
//
// One request per cycle is sustained while m_axis_tready stays high; an accepted request
// waits in the input register, then moves to the result register with the state update.
// Reset clears all raw and stable rows and loads the settle counter with five.
// A stalled result holds the request in the input register; s_axis_tready then drops.
module key_matrix_scan_debouncer
    import kmsd_pkg::*;
#(
    parameter int ROWS = ROWS_DEFAULT,
    parameter int COLS = COLS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // Fields from bit 0: row_index[3:0], column_levels[10:4], zero padding.
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // Fields from bit 0: stable_row[6:0], settled[7], committed[8], zero padding.
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   cfg_we,
    input  logic [COUNT_W-1:0]     cfg_wdata
);

    logic               in_valid_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [LEVEL_W-1:0] levels_reg;
    logic               last_reg;
    logic               out_valid_reg;
    kmsd_res_t          out_reg;
    logic               advance;
    kmsd_req_t          req;
    kmsd_res_t          res;

    assign advance = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_comb
    begin
        req.fire = advance;
        req.row_index = row_reg;
        req.column_levels = levels_reg;
        req.end_of_scan = last_reg;
    end

    kmsd_core #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            row_reg <= s_axis_tdata[ROW_W-1:0];
            levels_reg <= s_axis_tdata[ROW_W+LEVEL_W-1:ROW_W];
            last_reg <= s_axis_tlast;
        end
        if (advance)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {(OUT_TDATA_W - LEVEL_W - 2)'(0), out_reg.committed,
                           out_reg.settled, out_reg.stable_row};

    a_commit_settles: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res.committed |-> res.settled)
        else $error("Commit reported without a settled matrix.");

    a_ready_only_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("Input stalled while the result side could move.");

    a_result_follows_advance: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (out_valid_reg && out_reg == $past(res)))
        else $error("Result register did not capture the processed request.");

endmodule

// ===== rtl/kmsd_core.sv =====
// Row state, settle counter and commit logic of the key matrix scan debouncer.
// Depends on kmsd_pkg.
module kmsd_core
    import kmsd_pkg::*;
#(
    parameter int ROWS = ROWS_DEFAULT,
    parameter int COLS = COLS_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [COUNT_W-1:0] cfg_wdata,
    input  kmsd_req_t          req,
    output kmsd_res_t          res
);

    localparam int SW = (COLS < LEVEL_W) ? COLS : LEVEL_W;
    localparam int IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic [SW-1:0]      raw_reg [ROWS];
    logic [SW-1:0]      stable_reg [ROWS];
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W-1:0] debounce_reg;

    logic [ROW_EXT_W-1:0] row_ext;
    logic [IDX_W-1:0]     idx;
    logic                 in_range;
    logic [SW-1:0]        pressed;
    logic                 changed;
    logic [COUNT_W-1:0]   count_load;
    logic                 decrement;
    logic                 commit;
    logic [SW-1:0]        stable_sel;

    always_comb
    begin
        row_ext = ROW_EXT_W'(req.row_index);
        idx = row_ext[IDX_W-1:0];
        in_range = (32'(row_ext) < ROWS);
        pressed = ~req.column_levels[SW-1:0];
        changed = in_range && (raw_reg[idx] != pressed);
        count_load = changed ? debounce_reg : count_reg;
        decrement = req.end_of_scan && (count_load != '0);
        count_next = decrement ? (count_load - COUNT_W'(1)) : count_load;
        commit = decrement && (count_next == '0);
        stable_sel = commit ? pressed : stable_reg[idx];
        res.stable_row = in_range ? LEVEL_W'(stable_sel) : '0;
        res.settled = (count_next == '0);
        res.committed = commit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RESET;
        end
        else if (cfg_we)
        begin
            debounce_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= DEBOUNCE_RESET;
            for (int i = 0; i < ROWS; i++)
            begin
                raw_reg[i] <= '0;
                stable_reg[i] <= '0;
            end
        end
        else if (req.fire)
        begin
            count_reg <= count_next;
            for (int i = 0; i < ROWS; i++)
            begin
                if (changed && (IDX_W'(i) == idx))
                begin
                    raw_reg[i] <= pressed;
                end
                if (commit)
                begin
                    stable_reg[i] <= (changed && (IDX_W'(i) == idx)) ? pressed : raw_reg[i];
                end
            end
        end
    end

endmodule
